[src/point_to_voxel_transform_assert.svh]
// Assertion macros used by the p2v_rot pipeline module.
// Each macro expects clk and rst_n in scope.
`ifndef POINT_TO_VOXEL_TRANSFORM_ASSERT_SVH
`define POINT_TO_VOXEL_TRANSFORM_ASSERT_SVH

`ifndef SYNTHESIS
`define P2V_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("p2v assertion failed");
`define P2V_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("p2v assertion failed");
`else
`define P2V_ASSERT(label, expr)
`define P2V_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[src/p2v_pkg.sv]
package p2v_pkg;

  localparam int POINT_FRAC_BITS = 16;

  localparam int FIX_W      = 32;
  localparam int COEF_W     = 16;
  localparam int COEF_FRAC  = 14;
  localparam int SCALE_FRAC = 16;
  localparam int OFF_SH     = POINT_FRAC_BITS + 6;
  localparam int FINAL_SH   = POINT_FRAC_BITS + COEF_FRAC;

  localparam int ROT_PROD_W = FIX_W + COEF_W;
  localparam int SCL_PROD_W = 2 * FIX_W;
  localparam int WIDE_W     = (FIX_W + OFF_SH + 3 > SCL_PROD_W + 1) ?
                              (FIX_W + OFF_SH + 3) : (SCL_PROD_W + 1);

  localparam int NUM_REGS   = 8;
  localparam int CFG_IDX_W  = $clog2(NUM_REGS);
  localparam int CFG_DATA_W = 64;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t REG_ROTATION_COEFFS  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_WORLD_ROT_SCALE  = cfg_idx_t'(1);
  localparam cfg_idx_t REG_WORLD_SCALE_XY   = cfg_idx_t'(2);
  localparam cfg_idx_t REG_WORLD_SCALE_Z    = cfg_idx_t'(3);
  localparam cfg_idx_t REG_INTR_OFFSET_XY   = cfg_idx_t'(4);
  localparam cfg_idx_t REG_INTR_OFFSET_Z    = cfg_idx_t'(5);
  localparam cfg_idx_t REG_ANCHOR_XY        = cfg_idx_t'(6);
  localparam cfg_idx_t REG_ANCHOR_Z         = cfg_idx_t'(7);

  localparam cfg_data_t REG_RESET [NUM_REGS] = '{
    64'h0000_4000_0000_4000,
    64'h0001_0000_0000_4000,
    64'h0001_0000_0001_0000,
    64'h0000_0000_0001_0000,
    64'h0,
    64'h0,
    64'h0,
    64'h0
  };

  typedef logic signed [FIX_W-1:0]      fix_t;
  typedef logic signed [COEF_W-1:0]     coef_t;
  typedef logic signed [WIDE_W-1:0]     wide_t;
  typedef logic signed [ROT_PROD_W-1:0] rot_prod_t;
  typedef logic signed [SCL_PROD_W-1:0] scl_prod_t;

  typedef struct packed {
    fix_t x;
    fix_t y;
    fix_t z;
    logic sat;
  } vec_t;

  typedef struct packed {
    coef_t c;
    coef_t s;
    fix_t  off_x;
    fix_t  off_y;
    fix_t  off_z;
    logic  to_int;
  } rot_cfg_t;

  typedef struct packed {
    fix_t sx;
    fix_t sy;
    fix_t sz;
  } scale_cfg_t;

  typedef struct packed {
    fix_t v;
    logic ovf;
  } sat_res_t;

  function automatic wide_t round_half_away(wide_t v, int unsigned sh);
    wide_t half;
    half = wide_t'(1) <<< (sh - 1);
    return (v + half - wide_t'(v[WIDE_W-1])) >>> sh;
  endfunction

  function automatic sat_res_t sat_fix(wide_t v);
    sat_res_t r;
    logic     fits;
    fits  = (&v[WIDE_W-1:FIX_W-1]) || (~|v[WIDE_W-1:FIX_W-1]);
    r.ovf = !fits;
    if (fits) begin
      r.v = v[FIX_W-1:0];
    end else if (v[WIDE_W-1]) begin
      r.v = {1'b1, {(FIX_W-1){1'b0}}};
    end else begin
      r.v = {1'b0, {(FIX_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic wide_t align_off(fix_t o);
    return wide_t'(o) <<< OFF_SH;
  endfunction

endpackage

[src/p2v_if.sv]
interface p2v_in_if;
  import p2v_pkg::*;
  logic valid;
  logic ready;
  fix_t point_x;
  fix_t point_y;
  fix_t point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

interface p2v_out_if;
  import p2v_pkg::*;
  logic valid;
  logic ready;
  fix_t block_x;
  fix_t block_y;
  fix_t block_z;
  logic saturated;

  modport source (output valid, output block_x, output block_y, output block_z,
                  output saturated, input ready);
  modport sink   (input valid, input block_x, input block_y, input block_z,
                  input saturated, output ready);
endinterface

[src/p2v_rot.sv]
`include "point_to_voxel_transform_assert.svh"

module p2v_rot
  import p2v_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  rot_cfg_t cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  vec_t     in_vec,
  output logic     out_valid,
  input  logic     out_ready,
  output vec_t     out_vec
);

  typedef struct packed {
    rot_prod_t xc;
    rot_prod_t zs;
    rot_prod_t xs;
    rot_prod_t zc;
    fix_t      y;
    logic      sat;
  } rot_stage_t;

  logic       va_r;
  logic       vb_r;
  logic       adv_a;
  logic       adv_b;
  rot_stage_t prod_nxt;
  rot_stage_t prod_r;
  vec_t       vec_nxt;
  vec_t       vec_r;
  wide_t      acc_x;
  wide_t      acc_y;
  wide_t      acc_z;
  sat_res_t   res_x;
  sat_res_t   res_y;
  sat_res_t   res_z;

  assign adv_b    = !vb_r || out_ready;
  assign adv_a    = !va_r || adv_b;
  assign in_ready = adv_a;

  always_comb begin
    prod_nxt.xc  = in_vec.x * cfg.c;
    prod_nxt.zs  = in_vec.z * cfg.s;
    prod_nxt.xs  = in_vec.x * cfg.s;
    prod_nxt.zc  = in_vec.z * cfg.c;
    prod_nxt.y   = in_vec.y;
    prod_nxt.sat = in_vec.sat;
  end

  always_comb begin
    acc_x = wide_t'(prod_r.xc) - wide_t'(prod_r.zs) + align_off(cfg.off_x);
    acc_y = (wide_t'(prod_r.y) <<< COEF_FRAC) + align_off(cfg.off_y);
    acc_z = wide_t'(prod_r.xs) + wide_t'(prod_r.zc) + align_off(cfg.off_z);
    if (cfg.to_int) begin
      res_x = sat_fix(round_half_away(acc_x, FINAL_SH));
      res_y = sat_fix(round_half_away(acc_y, FINAL_SH));
      res_z = sat_fix(round_half_away(acc_z, FINAL_SH));
    end else begin
      res_x = sat_fix(round_half_away(acc_x, COEF_FRAC));
      res_y = sat_fix(round_half_away(acc_y, COEF_FRAC));
      res_z = sat_fix(round_half_away(acc_z, COEF_FRAC));
    end
    vec_nxt.x   = res_x.v;
    vec_nxt.y   = res_y.v;
    vec_nxt.z   = res_z.v;
    vec_nxt.sat = prod_r.sat || res_x.ovf || res_y.ovf || res_z.ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (adv_a) begin
        va_r <= in_valid;
      end
      if (adv_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && in_valid) begin
      prod_r <= prod_nxt;
    end
    if (adv_b && va_r) begin
      vec_r <= vec_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_vec   = vec_r;

  `P2V_ASSERT_NEXT(a_hold_on_stall, vb_r && !out_ready, vb_r && $stable(vec_r))
  `P2V_ASSERT_NEXT(a_sat_sticky, adv_b && va_r && prod_r.sat, vb_r && vec_r.sat)
  `P2V_ASSERT(a_ready_when_empty, !va_r |-> in_ready)

endmodule

[src/p2v_scale.sv]
module p2v_scale
  import p2v_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  scale_cfg_t cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  vec_t       in_vec,
  output logic       out_valid,
  input  logic       out_ready,
  output vec_t       out_vec
);

  typedef struct packed {
    scl_prod_t x;
    scl_prod_t y;
    scl_prod_t z;
    logic      sat;
  } scl_stage_t;

  logic       va_r;
  logic       vb_r;
  logic       adv_a;
  logic       adv_b;
  scl_stage_t prod_nxt;
  scl_stage_t prod_r;
  vec_t       vec_nxt;
  vec_t       vec_r;
  sat_res_t   res_x;
  sat_res_t   res_y;
  sat_res_t   res_z;

  assign adv_b    = !vb_r || out_ready;
  assign adv_a    = !va_r || adv_b;
  assign in_ready = adv_a;

  always_comb begin
    prod_nxt.x   = in_vec.x * cfg.sx;
    prod_nxt.y   = in_vec.y * cfg.sy;
    prod_nxt.z   = in_vec.z * cfg.sz;
    prod_nxt.sat = in_vec.sat;
  end

  always_comb begin
    res_x       = sat_fix(round_half_away(wide_t'(prod_r.x), SCALE_FRAC));
    res_y       = sat_fix(round_half_away(wide_t'(prod_r.y), SCALE_FRAC));
    res_z       = sat_fix(round_half_away(wide_t'(prod_r.z), SCALE_FRAC));
    vec_nxt.x   = res_x.v;
    vec_nxt.y   = res_y.v;
    vec_nxt.z   = res_z.v;
    vec_nxt.sat = prod_r.sat || res_x.ovf || res_y.ovf || res_z.ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (adv_a) begin
        va_r <= in_valid;
      end
      if (adv_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && in_valid) begin
      prod_r <= prod_nxt;
    end
    if (adv_b && va_r) begin
      vec_r <= vec_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_vec   = vec_r;

endmodule

[src/point_to_voxel_transform.sv]
// Each accepted request passes through five units of two register stages each
// (pitch, scale, yaw, world scale, world yaw) before its result is valid.
// Throughput (out_ch.ready high): one request per cycle; each stage stalls only
// while the stage after it is full, and in_ch.ready follows the first stage's room.
// Reset (synchronous, rst_n low) empties the pipeline and loads register defaults.
module point_to_voxel_transform
  import p2v_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  p2v_in_if.sink    in_ch,
  p2v_out_if.source out_ch,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_index,
  input  cfg_data_t cfg_data
);

  cfg_data_t  regs_r [NUM_REGS];

  rot_cfg_t   pitch_cfg;
  rot_cfg_t   yaw_cfg;
  rot_cfg_t   world_cfg;
  scale_cfg_t intr_scale_cfg;
  scale_cfg_t world_scale_cfg;

  vec_t pitch_in;
  vec_t pitch_out;
  vec_t scl1_in;
  vec_t scl1_out;
  vec_t yaw_out;
  vec_t scl2_out;
  vec_t world_out;

  logic pitch_valid, pitch_ready;
  logic scl1_valid, scl1_ready;
  logic yaw_valid, yaw_ready;
  logic scl2_valid, scl2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= REG_RESET;
    end else if (cfg_we) begin
      regs_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    pitch_cfg.c      = regs_r[REG_ROTATION_COEFFS][15:0];
    pitch_cfg.s      = regs_r[REG_ROTATION_COEFFS][31:16];
    pitch_cfg.off_x  = '0;
    pitch_cfg.off_y  = '0;
    pitch_cfg.off_z  = '0;
    pitch_cfg.to_int = 1'b0;

    yaw_cfg.c        = regs_r[REG_ROTATION_COEFFS][47:32];
    yaw_cfg.s        = regs_r[REG_ROTATION_COEFFS][63:48];
    yaw_cfg.off_x    = regs_r[REG_INTR_OFFSET_XY][31:0];
    yaw_cfg.off_y    = regs_r[REG_INTR_OFFSET_XY][63:32];
    yaw_cfg.off_z    = regs_r[REG_INTR_OFFSET_Z][31:0];
    yaw_cfg.to_int   = 1'b0;

    world_cfg.c      = regs_r[REG_WORLD_ROT_SCALE][15:0];
    world_cfg.s      = regs_r[REG_WORLD_ROT_SCALE][31:16];
    world_cfg.off_x  = regs_r[REG_ANCHOR_XY][31:0];
    world_cfg.off_y  = regs_r[REG_ANCHOR_XY][63:32];
    world_cfg.off_z  = regs_r[REG_ANCHOR_Z][31:0];
    world_cfg.to_int = 1'b1;

    intr_scale_cfg.sx = regs_r[REG_WORLD_ROT_SCALE][63:32];
    intr_scale_cfg.sy = regs_r[REG_WORLD_ROT_SCALE][63:32];
    intr_scale_cfg.sz = regs_r[REG_WORLD_ROT_SCALE][63:32];

    world_scale_cfg.sx = regs_r[REG_WORLD_SCALE_XY][31:0];
    world_scale_cfg.sy = regs_r[REG_WORLD_SCALE_XY][63:32];
    world_scale_cfg.sz = regs_r[REG_WORLD_SCALE_Z][31:0];
  end

  // pitch turns the (z, y) plane: route z, y into the rotated lanes, x through
  always_comb begin
    pitch_in.x   = in_ch.point_z;
    pitch_in.y   = in_ch.point_x;
    pitch_in.z   = in_ch.point_y;
    pitch_in.sat = 1'b0;
    scl1_in.x    = pitch_out.y;
    scl1_in.y    = pitch_out.z;
    scl1_in.z    = pitch_out.x;
    scl1_in.sat  = pitch_out.sat;
  end

  p2v_rot u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (pitch_cfg),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_vec    (pitch_in),
    .out_valid (pitch_valid),
    .out_ready (pitch_ready),
    .out_vec   (pitch_out)
  );

  p2v_scale u_intr_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (intr_scale_cfg),
    .in_valid  (pitch_valid),
    .in_ready  (pitch_ready),
    .in_vec    (scl1_in),
    .out_valid (scl1_valid),
    .out_ready (scl1_ready),
    .out_vec   (scl1_out)
  );

  p2v_rot u_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (yaw_cfg),
    .in_valid  (scl1_valid),
    .in_ready  (scl1_ready),
    .in_vec    (scl1_out),
    .out_valid (yaw_valid),
    .out_ready (yaw_ready),
    .out_vec   (yaw_out)
  );

  p2v_scale u_world_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (world_scale_cfg),
    .in_valid  (yaw_valid),
    .in_ready  (yaw_ready),
    .in_vec    (yaw_out),
    .out_valid (scl2_valid),
    .out_ready (scl2_ready),
    .out_vec   (scl2_out)
  );

  p2v_rot u_world_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (world_cfg),
    .in_valid  (scl2_valid),
    .in_ready  (scl2_ready),
    .in_vec    (scl2_out),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_vec   (world_out)
  );

  assign out_ch.block_x   = world_out.x;
  assign out_ch.block_y   = world_out.y;
  assign out_ch.block_z   = world_out.z;
  assign out_ch.saturated = world_out.sat;

endmodule
